// ===== hw/rtl/lobm_pkg.sv =====
// ----------------------------------------------------------------------------
// lobm_pkg: shared types and constants of the order book matcher
// Slot record, cell control word, order kinds, event kinds and states.
// ----------------------------------------------------------------------------
package lobm_pkg;

    // order kinds on the input channel
    localparam logic [1:0] FUNC_LIMIT  = 2'd0;
    localparam logic [1:0] FUNC_MARKET = 2'd1;
    localparam logic [1:0] FUNC_CANCEL = 2'd2;

    // event kinds on the output channel
    localparam logic [1:0] KIND_ADDED    = 2'd0;
    localparam logic [1:0] KIND_FILL     = 2'd1;
    localparam logic [1:0] KIND_REJECTED = 2'd2;

    // most fills one market order may cause
    localparam int MAX_RESULTS = 32;
    localparam int NW          = $clog2(MAX_RESULTS + 1);

    // one resting order
    typedef struct packed {
        logic        side;
        logic [7:0]  price;
        logic [31:0] id;
        logic [31:0] rem;
    } t_slot;

    // cell operations
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_SETREM,
        CELL_SHIFT
    } t_cell_op;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FILL
    } t_state;

endpackage

// ===== hw/rtl/lobm_if.sv =====
// ----------------------------------------------------------------------------
// lobm_if: order and event channels
// Valid/ready channels carrying one order word and one event word.
// ----------------------------------------------------------------------------
interface lobm_ord_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic        side;
    logic [31:0] order_id;
    logic [31:0] quantity;
    logic [7:0]  price_tick;

    modport source (output valid, func, side, order_id, quantity, price_tick,
                    input ready);
    modport sink   (input valid, func, side, order_id, quantity, price_tick,
                    output ready);
endinterface

interface lobm_evt_if;
    logic        valid;
    logic        ready;
    logic [1:0]  out_kind;
    logic [31:0] out_order_id;
    logic [31:0] out_quantity;
    logic [7:0]  out_price_tick;
    logic        out_side;
    logic        last;

    modport source (output valid, out_kind, out_order_id, out_quantity,
                    out_price_tick, out_side, last, input ready);
    modport sink   (input valid, out_kind, out_order_id, out_quantity,
                    out_price_tick, out_side, last, output ready);
endinterface

// ===== hw/rtl/limit_order_book_matcher.sv =====
// ----------------------------------------------------------------------------
// limit_order_book_matcher: price-time priority order book
// Row of slot cells kept in arrival order with a scanning controller.
// ----------------------------------------------------------------------------
// Usage:
//   i_ord takes one order word (limit, market or cancel); o_evt gives event
//   words, the final word of an order flagged by last.
//   A limit order is taken in a single handshake; its added or rejected word
//   appears in the next cycle and the next order may follow right after
//   while the receiver is ready. A market order scans the U resting slots
//   once per fill, one slot per cycle, then issues the fill word in ST_FILL,
//   which waits while the receiver stalls. Emptied slots are closed by the
//   cells handing records down. A cancel scans up to the U resting slots,
//   stopping at the first match.
//   Reset empties the book at once; the slot contents need no clearing.
//   A stalled receiver holds the event word in the output register; the
//   controller waits before the next fill and takes no order until free.
// ----------------------------------------------------------------------------
module limit_order_book_matcher
    import lobm_pkg::*;
#(
    parameter int PRICE_TICKS = 256,
    parameter int MAX_RESTING = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lobm_ord_if.sink    i_ord,
    lobm_evt_if.source  o_evt
);

    localparam int IW = (MAX_RESTING > 1) ? $clog2(MAX_RESTING) : 1;
    localparam int UW = $clog2(MAX_RESTING + 1);

    t_state r_state, n_state;

    // control
    logic [UW-1:0] r_used, n_used;
    logic [UW-1:0] r_cnt [2];
    logic [UW-1:0] n_cnt [2];
    logic [IW-1:0] r_ptr, n_ptr;
    logic [NW-1:0] r_nres, n_nres;
    logic          r_found, n_found;
    logic          r_ov, n_ov;

    // order being worked
    logic [1:0]    r_func, n_func;
    logic          r_side, n_side;
    logic [31:0]   r_id, n_id;
    logic [31:0]   r_left, n_left;
    logic [7:0]    r_price, n_price;

    // best candidate
    t_slot         r_best, n_best;
    logic [IW-1:0] r_bidx, n_bidx;

    // output word
    logic [1:0]    r_o_kind, n_o_kind;
    logic [31:0]   r_o_id, n_o_id;
    logic [31:0]   r_o_qty, n_o_qty;
    logic [7:0]    r_o_price, n_o_price;
    logic          r_o_side, n_o_side;
    logic          r_o_last, n_o_last;

    // cell row
    t_cell_op      w_op;
    logic [IW-1:0] w_idx;
    t_slot         w_wr;
    t_slot         w_slot [MAX_RESTING];
    t_slot         w_sel;

    logic          w_out_free;
    logic          w_accept;
    logic          w_opp;
    logic [7:0]    w_price_sat;
    logic          w_scan_end;
    logic          w_cand;
    logic          w_better;
    logic          w_match;
    logic [31:0]   w_fill;
    logic [31:0]   w_rem_new;
    logic          w_more;
    logic          w_last;

    // cells
    for (genvar g = 0; g < MAX_RESTING; g++) begin : g_cell
        t_slot w_next;
        if (g + 1 < MAX_RESTING) begin : g_mid
            assign w_next = w_slot[g+1];
        end else begin : g_top
            assign w_next = w_slot[g];
        end
        lobm_cell #(
            .IW  (IW),
            .POS (g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_op   (w_op),
            .i_idx  (w_idx),
            .i_wr   (w_wr),
            .i_next (w_next),
            .o_slot (w_slot[g])
        );
    end

    // handshake and helpers
    assign w_out_free = !r_ov || o_evt.ready;
    assign i_ord.ready = (r_state == ST_IDLE) && w_out_free;
    assign w_accept   = i_ord.valid && i_ord.ready;
    assign w_opp      = !r_side;
    assign w_sel      = w_slot[r_ptr];
    assign w_scan_end = ((UW'(r_ptr) + UW'(1)) >= r_used);

    always_comb begin
        if ({9'd0, i_ord.price_tick} >= 17'(PRICE_TICKS)) begin
            w_price_sat = 8'(PRICE_TICKS - 1);
        end else begin
            w_price_sat = i_ord.price_tick;
        end
    end

    // scan compares
    assign w_cand   = (w_sel.side == w_opp);
    assign w_better = !r_found ||
                      (w_opp ? (w_sel.price < r_best.price)
                             : (w_sel.price > r_best.price));
    assign w_match  = (w_sel.side == r_side) && (w_sel.price == r_price) &&
                      (w_sel.id == r_id);

    // fill arithmetic
    assign w_fill    = (r_left < r_best.rem) ? r_left : r_best.rem;
    assign w_rem_new = r_best.rem - w_fill;
    assign w_more    = (w_rem_new == 32'd0) ? (r_cnt[w_opp] > UW'(1))
                                            : 1'b1;
    assign w_last    = (r_left == w_fill) || (r_nres == NW'(MAX_RESULTS - 1)) ||
                       !w_more;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_ord.func == FUNC_MARKET) begin
                        if (i_ord.quantity != 32'd0 && r_cnt[!i_ord.side] != UW'(0))
                            n_state = ST_SCAN;
                    end else if (i_ord.func == FUNC_CANCEL) begin
                        if (r_used != UW'(0)) n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (r_func == FUNC_CANCEL) begin
                    if (w_match || w_scan_end) n_state = ST_IDLE;
                end else if (w_scan_end) begin
                    n_state = ST_FILL;
                end
            end
            ST_FILL: begin
                if (w_out_free) n_state = w_last ? ST_IDLE : ST_SCAN;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and cell control
    always_comb begin
        n_used    = r_used;
        n_cnt     = r_cnt;
        n_ptr     = r_ptr;
        n_nres    = r_nres;
        n_found   = r_found;
        n_ov      = r_ov && !o_evt.ready;
        n_func    = r_func;
        n_side    = r_side;
        n_id      = r_id;
        n_left    = r_left;
        n_price   = r_price;
        n_best    = r_best;
        n_bidx    = r_bidx;
        n_o_kind  = r_o_kind;
        n_o_id    = r_o_id;
        n_o_qty   = r_o_qty;
        n_o_price = r_o_price;
        n_o_side  = r_o_side;
        n_o_last  = r_o_last;
        w_op      = CELL_HOLD;
        w_idx     = r_ptr;
        w_wr      = r_best;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_func  = i_ord.func;
                    n_side  = i_ord.side;
                    n_id    = i_ord.order_id;
                    n_left  = i_ord.quantity;
                    n_price = w_price_sat;
                    n_ptr   = '0;
                    n_found = 1'b0;
                    n_nres  = '0;
                    if (i_ord.func == FUNC_LIMIT) begin
                        n_ov      = 1'b1;
                        n_o_id    = i_ord.order_id;
                        n_o_qty   = i_ord.quantity;
                        n_o_price = w_price_sat;
                        n_o_side  = i_ord.side;
                        n_o_last  = 1'b1;
                        if (r_used >= UW'(MAX_RESTING)) begin
                            n_o_kind = KIND_REJECTED;
                        end else begin
                            n_o_kind   = KIND_ADDED;
                            w_op       = CELL_LOAD;
                            w_idx      = IW'(r_used);
                            w_wr.side  = i_ord.side;
                            w_wr.price = w_price_sat;
                            w_wr.id    = i_ord.order_id;
                            w_wr.rem   = i_ord.quantity;
                            n_used     = r_used + UW'(1);
                            n_cnt[i_ord.side] = r_cnt[i_ord.side] + UW'(1);
                        end
                    end
                end
            end
            ST_SCAN: begin
                n_ptr = r_ptr + IW'(1);
                if (r_func == FUNC_CANCEL) begin
                    if (w_match) begin
                        w_op   = CELL_SHIFT;
                        w_idx  = r_ptr;
                        n_used = r_used - UW'(1);
                        n_cnt[r_side] = r_cnt[r_side] - UW'(1);
                    end
                end else if (w_cand && w_better) begin
                    n_found = 1'b1;
                    n_best  = w_sel;
                    n_bidx  = r_ptr;
                end
            end
            ST_FILL: begin
                if (w_out_free) begin
                    n_ov      = 1'b1;
                    n_o_kind  = KIND_FILL;
                    n_o_id    = r_best.id;
                    n_o_qty   = w_fill;
                    n_o_price = r_best.price;
                    n_o_side  = w_opp;
                    n_o_last  = w_last;
                    n_left    = r_left - w_fill;
                    n_nres    = r_nres + NW'(1);
                    n_ptr     = '0;
                    n_found   = 1'b0;
                    w_idx     = r_bidx;
                    w_wr.rem  = w_rem_new;
                    if (w_rem_new == 32'd0) begin
                        w_op   = CELL_SHIFT;
                        n_used = r_used - UW'(1);
                        n_cnt[w_opp] = r_cnt[w_opp] - UW'(1);
                    end else begin
                        w_op   = CELL_SETREM;
                    end
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_used   <= '0;
            r_cnt[0] <= '0;
            r_cnt[1] <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_used   <= n_used;
            r_cnt    <= n_cnt;
            r_ov     <= n_ov;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_ptr     <= n_ptr;
        r_nres    <= n_nres;
        r_found   <= n_found;
        r_func    <= n_func;
        r_side    <= n_side;
        r_id      <= n_id;
        r_left    <= n_left;
        r_price   <= n_price;
        r_best    <= n_best;
        r_bidx    <= n_bidx;
        r_o_kind  <= n_o_kind;
        r_o_id    <= n_o_id;
        r_o_qty   <= n_o_qty;
        r_o_price <= n_o_price;
        r_o_side  <= n_o_side;
        r_o_last  <= n_o_last;
    end

    // event word
    assign o_evt.valid          = r_ov;
    assign o_evt.out_kind       = r_o_kind;
    assign o_evt.out_order_id   = r_o_id;
    assign o_evt.out_quantity   = r_o_qty;
    assign o_evt.out_price_tick = r_o_price;
    assign o_evt.out_side       = r_o_side;
    assign o_evt.last           = r_o_last;

endmodule

// ===== hw/rtl/lobm_cell.sv =====
// ----------------------------------------------------------------------------
// lobm_cell: one resting order slot
// Loads a new order, updates its remaining quantity, or takes the record of
// its upper neighbor when a slot at or below it is removed.
// ----------------------------------------------------------------------------
module lobm_cell
    import lobm_pkg::*;
#(
    parameter int IW  = 5,
    parameter int POS = 0
) (
    input  logic          i_clk,
    input  t_cell_op      i_op,
    input  logic [IW-1:0] i_idx,
    input  t_slot         i_wr,
    input  t_slot         i_next,
    output t_slot         o_slot
);

    t_slot r_slot;
    logic  w_hit;
    logic  w_above;

    assign w_hit   = (i_idx == IW'(POS));
    assign w_above = (IW'(POS) >= i_idx);

    // slot register
    always_ff @(posedge i_clk) begin
        case (i_op)
            CELL_LOAD: begin
                if (w_hit) r_slot <= i_wr;
            end
            CELL_SETREM: begin
                if (w_hit) r_slot.rem <= i_wr.rem;
            end
            CELL_SHIFT: begin
                if (w_above) r_slot <= i_next;
            end
            default: ;
        endcase
    end

    assign o_slot = r_slot;

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: order book matcher testbench
// Drives limit, market, cancel and unknown-kind orders with random gaps and
// checks every event word against a behavioral copy of the book in this module.
// ----------------------------------------------------------------------------
module tb_top;
    import lobm_pkg::*;

    localparam int BOOK_DEPTH  = 32;
    localparam int GAP_MAX     = 16;
    localparam int QUIET_LIMIT = 20000;

    // order kind the block ignores
    localparam logic [1:0] FUNC_NONE = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic        side;
        logic [31:0] order_id;
        logic [31:0] quantity;
        logic [7:0]  price_tick;
    } t_order;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] order_id;
        logic [31:0] quantity;
        logic [7:0]  price_tick;
        logic        side;
        logic        last;
    } t_event;

    logic i_clk;
    logic i_rst_n;

    lobm_ord_if ord_ch ();
    lobm_evt_if evt_ch ();

    limit_order_book_matcher #(.PRICE_TICKS(256), .MAX_RESTING(BOOK_DEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ord   (ord_ch.sink),
        .o_evt   (evt_ch.source)
    );

    // book copy, oldest order at index 0
    t_slot  book_q[$];
    t_order order_q[$];
    t_event event_exp_q[$];

    int  mismatch_cnt;
    int  quiet_cycles;
    bit  hold_evt;       // long receiver hold-off request
    bit  drain_req;      // sender waits for every event
    int  hold_cnt;

    // append one order to the pending queue
    task automatic add_order(input t_order o);
        order_q = {order_q, o};
    endtask

    // append one expected event word
    task automatic add_event(input t_event ev);
        event_exp_q = {event_exp_q, ev};
    endtask

    // apply one order to the book copy and queue its events
    task automatic book_apply(input t_order o);
        t_event ev;
        t_slot  s;
        logic [31:0] left;
        logic [31:0] fq;
        logic        opp;
        int n;
        int best;
        n = 0;
        ev = '0;
        case (o.func)
            FUNC_LIMIT: begin
                ev.order_id = o.order_id;
                ev.quantity = o.quantity;
                ev.price_tick = o.price_tick;
                ev.side = o.side;
                ev.last = 1'b1;
                if (book_q.size() >= BOOK_DEPTH) begin
                    ev.kind = KIND_REJECTED;
                end else begin
                    ev.kind = KIND_ADDED;
                    s.side = o.side;
                    s.price = o.price_tick;
                    s.id = o.order_id;
                    s.rem = o.quantity;
                    book_q = {book_q, s};
                end
                add_event(ev);
            end
            FUNC_MARKET: begin
                opp = ~o.side;
                left = o.quantity;
                while (left != 0 && n < MAX_RESULTS) begin
                    best = -1;
                    foreach (book_q[i]) begin
                        if (book_q[i].side == opp) begin
                            if (best < 0) best = i;
                            else if (opp ? book_q[i].price < book_q[best].price
                                         : book_q[i].price > book_q[best].price)
                                best = i;
                        end
                    end
                    if (best < 0) break;
                    fq = (left < book_q[best].rem) ? left : book_q[best].rem;
                    left -= fq;
                    book_q[best].rem -= fq;
                    ev.kind = KIND_FILL;
                    ev.order_id = book_q[best].id;
                    ev.quantity = fq;
                    ev.price_tick = book_q[best].price;
                    ev.side = opp;
                    ev.last = 1'b0;
                    add_event(ev);
                    n++;
                    if (book_q[best].rem == 0) book_q.delete(best);
                end
                if (n > 0) event_exp_q[event_exp_q.size() - 1].last = 1'b1;
            end
            FUNC_CANCEL: begin
                foreach (book_q[i]) begin
                    if (book_q[i].side == o.side && book_q[i].price == o.price_tick &&
                        book_q[i].id == o.order_id) begin
                        book_q.delete(i);
                        break;
                    end
                end
            end
            default: ;
        endcase
    endtask

    function automatic t_order mk_order(logic [1:0] f, logic sd, logic [31:0] id,
                                        logic [31:0] q, logic [7:0] p);
        t_order o;
        o.func = f;
        o.side = sd;
        o.order_id = id;
        o.quantity = q;
        o.price_tick = p;
        return o;
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // driver
    int  ord_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ord_ch.valid <= 1'b0;
            ord_gap = 0;
        end else begin
            // idle count drawn per accepted word
            if (ord_ch.valid && ord_ch.ready) begin
                book_apply(order_q.pop_front());
                ord_gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, GAP_MAX);
            end else if (!ord_ch.valid && ord_gap != 0) begin
                ord_gap = ord_gap - 1;
            end
            if (ord_ch.valid && !ord_ch.ready) begin
                // keep offering the same word
            end else if (order_q.size() == 0 || ord_gap != 0 ||
                         (drain_req && event_exp_q.size() != 0)) begin
                ord_ch.valid <= 1'b0;
            end else begin
                ord_ch.valid <= 1'b1;
                ord_ch.func <= order_q[0].func;
                ord_ch.side <= order_q[0].side;
                ord_ch.order_id <= order_q[0].order_id;
                ord_ch.quantity <= order_q[0].quantity;
                ord_ch.price_tick <= order_q[0].price_tick;
            end
        end
    end

    // long hold-off counter of the receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) hold_cnt <= 0;
        else if (hold_evt && hold_cnt < 400) hold_cnt <= hold_cnt + 1;
        else if (!hold_evt) hold_cnt <= 0;
    end

    // monitor and receiver
    int     evt_gap;
    t_event got;
    t_event want;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            evt_ch.ready <= 1'b0;
            evt_gap = 0;
            quiet_cycles <= 0;
        end else begin
            if (evt_ch.valid && evt_ch.ready) begin
                got.kind = evt_ch.out_kind;
                got.order_id = evt_ch.out_order_id;
                got.quantity = evt_ch.out_quantity;
                got.price_tick = evt_ch.out_price_tick;
                got.side = evt_ch.out_side;
                got.last = evt_ch.last;
                if (event_exp_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected event word %p", got);
                end else begin
                    want = event_exp_q.pop_front();
                    if (got !== want) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("event mismatch: expected %p, actual %p", want, got);
                    end
                end
                evt_gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, GAP_MAX);
            end else if (evt_gap != 0) begin
                evt_gap = evt_gap - 1;
            end
            evt_ch.ready <= (evt_gap == 0) && !(hold_evt && hold_cnt < 400);
            if ((ord_ch.valid && ord_ch.ready) || (evt_ch.valid && evt_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // random order with small prices so sides overlap
    function automatic t_order rand_order();
        t_order o;
        int r;
        r = $urandom_range(0, 99);
        o.side = 1'($urandom_range(0, 1));
        o.order_id = $urandom_range(0, 7) == 0 ? $urandom() : $urandom_range(0, 15);
        o.quantity = $urandom_range(0, 9) == 0 ? $urandom() : $urandom_range(0, 40);
        o.price_tick = $urandom_range(0, 9) == 0 ? 8'($urandom_range(0, 255))
                                                 : 8'($urandom_range(100, 107));
        if (r < 3) o.func = FUNC_NONE;
        else if (r < 55) o.func = FUNC_LIMIT;
        else if (r < 80) o.func = FUNC_MARKET;
        else o.func = FUNC_CANCEL;
        return o;
    endfunction

    // stimulus
    initial begin
        i_rst_n = 1'b0;
        ord_ch.valid = 1'b0;
        ord_ch.func = '0;
        ord_ch.side = 1'b0;
        ord_ch.order_id = '0;
        ord_ch.quantity = '0;
        ord_ch.price_tick = '0;
        evt_ch.ready = 1'b0;
        mismatch_cnt = 0;
        hold_evt = 1'b0;
        drain_req = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, zero quantities, cancels, unknown kind
        add_order(mk_order(FUNC_MARKET, 1'b0, 32'd1, 32'd10, 8'd0));
        add_order(mk_order(FUNC_LIMIT, 1'b1, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'd255));
        add_order(mk_order(FUNC_LIMIT, 1'b1, 32'd0, 32'd0, 8'd0));
        add_order(mk_order(FUNC_LIMIT, 1'b1, 32'd5, 32'd7, 8'd0));
        add_order(mk_order(FUNC_LIMIT, 1'b0, 32'd6, 32'd9, 8'd200));
        add_order(mk_order(FUNC_LIMIT, 1'b0, 32'd6, 32'd4, 8'd200));
        add_order(mk_order(FUNC_MARKET, 1'b0, 32'd9, 32'd0, 8'd0));
        add_order(mk_order(FUNC_NONE, 1'b1, 32'd9, 32'd9, 8'd9));
        add_order(mk_order(FUNC_CANCEL, 1'b0, 32'd6, 32'd0, 8'd199));
        add_order(mk_order(FUNC_CANCEL, 1'b0, 32'd6, 32'd0, 8'd200));
        add_order(mk_order(FUNC_MARKET, 1'b0, 32'd2, 32'd3, 8'hAA));
        add_order(mk_order(FUNC_MARKET, 1'b1, 32'd3, 32'hFFFFFFFF, 8'h55));
        add_order(mk_order(FUNC_MARKET, 1'b0, 32'd4, 32'hFFFFFFFF, 8'd0));
        // fill the book and go one past it
        for (int i = 0; i < 33; i++)
            add_order(mk_order(FUNC_LIMIT, 1'b0, i, i % 3, 8'(50 + (i % 4))));
        // market sweep over the whole buy side with the receiver held off
        wait (order_q.size() == 0);
        hold_evt = 1'b1;
        add_order(mk_order(FUNC_MARKET, 1'b1, 32'd0, 32'hFFFFFFFF, 8'd0));
        for (int i = 0; i < 6; i++)
            add_order(mk_order(FUNC_LIMIT, 1'b1, 100 + i, 5, 8'd60));
        repeat (450) @(posedge i_clk);
        hold_evt = 1'b0;
        wait (order_q.size() == 0 && event_exp_q.size() == 0);

        // random part; one drained pause midway
        for (int i = 0; i < 60; i++) begin
            if (i == 30) begin
                wait (order_q.size() == 0);
                drain_req = 1'b1;
                wait (event_exp_q.size() == 0);
                drain_req = 1'b0;
            end
            add_order(rand_order());
        end

        wait (order_q.size() == 0 && !ord_ch.valid);
        wait (event_exp_q.size() == 0);
        repeat (200) @(posedge i_clk);
        if (mismatch_cnt == 0 && event_exp_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
